// ===== rtl/sepv_pkg.sv =====
package sepv_pkg;

  localparam int STRIDE_W    = 16;
  localparam int MAX_COUNT_W = 31;
  localparam int TS_W        = 32;
  localparam int COUNT_W     = 32;
  localparam int VEL_W       = 26;
  localparam int CFG_DATA_W  = 31;
  localparam int CFG_INDEX_W = 1;

  // Half a stride in micrometres over microseconds gives mm/s after scaling by 500.
  localparam int VEL_SCALE   = 500;
  localparam int SCALE_W     = 9;
  localparam int DIVIDEND_W  = STRIDE_W + SCALE_W;
  localparam int DIVISOR_W   = TS_W;

  typedef enum logic [1:0] {
    OP_BACK_EDGE    = 2'd0,
    OP_FRONT_EDGE   = 2'd1,
    OP_FRONT_MARKER = 2'd2,
    OP_BACK_MARKER  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STRIDE    = 1'd0,
    REG_MAX_COUNT = 1'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV
  } state_t;

endpackage

// ===== rtl/sepv_if.sv =====
interface sepv_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic                      back_level;
  logic                      front_level;
  logic [sepv_pkg::TS_W-1:0] timestamp_us;

  modport source (output valid, opcode, back_level, front_level, timestamp_us, input ready);
  modport sink   (input valid, opcode, back_level, front_level, timestamp_us, output ready);
endinterface

interface sepv_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sepv_pkg::COUNT_W-1:0] position_count;
  logic signed [sepv_pkg::VEL_W-1:0]   velocity_mm_s;
  logic                                moving_right;

  modport source (output valid, position_count, velocity_mm_s, moving_right, input ready);
  modport sink   (input valid, position_count, velocity_mm_s, moving_right, output ready);
endinterface

// ===== rtl/sepv_div.sv =====
module sepv_div #(
  parameter int DividendWidth = sepv_pkg::DIVIDEND_W,
  parameter int DivisorWidth  = sepv_pkg::DIVISOR_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DividendWidth-1:0] dividend,
  input  logic [DivisorWidth-1:0]  divisor,
  output logic                     done,
  output logic [DividendWidth-1:0] quotient
);

  localparam int CntW = (DividendWidth > 1) ? $clog2(DividendWidth) : 1;

  logic                  busy;
  logic [CntW-1:0]       cnt;
  logic [DivisorWidth-1:0] rem;
  logic [DividendWidth-1:0] quo;
  logic [DivisorWidth:0] trial;
  logic [DivisorWidth:0] diff;
  logic                  fits;

  // One restoring step per cycle, quotient bits shift in from the bottom.
  assign trial = {rem, quo[DividendWidth-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(DividendWidth - 1);
      end else if (busy) begin
        cnt <= cnt - CntW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DivisorWidth-1:0] : trial[DivisorWidth-1:0];
      quo <= {quo[DividendWidth-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/stripe_encoder_position_velocity.sv =====
// Stripe encoder position and velocity decoder.
// Events arrive on the events channel (valid/ready): an opcode, both channel
// levels and a microsecond timestamp. Each event yields exactly one transfer
// on the results channel with the stripe count, the velocity in mm/s and the
// last decoded direction after that event.
// The configuration port writes stride_um (index 0) and max_count (index 1)
// on any cycle with cfg_we high; it must be written only while the block is
// idle, which the block itself does not enforce. End markers and channel
// edges that change direction give their result in the cycle after the
// transfer. An edge that repeats the direction runs the velocity division in
// a single restoring divider, one quotient bit per cycle, in state ST_DIV.
// The block takes one event at a time: ready is high only with no event in
// work and the result register empty or being taken in that cycle. A stalled
// receiver holds the result and keeps the events channel stalled.
// Synchronous reset clears the count, time, velocity and both registers, sets
// the direction to none and empties the result register.
module stripe_encoder_position_velocity (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sepv_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sepv_pkg::CFG_DATA_W-1:0]     cfg_data,
  sepv_in_if.sink                             events,
  sepv_out_if.source                          results
);

  sepv_pkg::state_t state, state_next;

  logic [sepv_pkg::STRIDE_W-1:0]         stride_um;
  logic [sepv_pkg::MAX_COUNT_W-1:0]      max_count;
  logic [sepv_pkg::COUNT_W-1:0]          stripe_pos;
  sepv_pkg::dir_t                        last_direction;
  logic [sepv_pkg::TS_W-1:0]             last_event_time;
  logic [sepv_pkg::VEL_W-1:0]            velocity_reg;
  logic                                  out_valid;

  logic [sepv_pkg::DIVIDEND_W-1:0]       dividend;
  logic [sepv_pkg::DIVISOR_W-1:0]        divisor;
  logic [sepv_pkg::DIVIDEND_W-1:0]       quotient;
  logic                                  div_start;
  logic                                  div_done;

  logic                                  accept;
  logic                                  is_edge;
  logic                                  is_repeat;
  sepv_pkg::dir_t                        edge_dir;
  logic [sepv_pkg::TS_W-1:0]             delta;
  logic                                  result_now;
  logic [sepv_pkg::VEL_W-1:0]            vel_mag;

  assign accept = events.valid && events.ready;

  always_comb begin
    case (sepv_pkg::opcode_t'(events.opcode))
      sepv_pkg::OP_BACK_EDGE: begin
        edge_dir = (events.back_level == events.front_level) ?
                   sepv_pkg::DIR_RIGHT : sepv_pkg::DIR_LEFT;
      end
      default: begin
        edge_dir = (events.back_level != events.front_level) ?
                   sepv_pkg::DIR_RIGHT : sepv_pkg::DIR_LEFT;
      end
    endcase
  end

  assign is_edge   = events.opcode inside {sepv_pkg::OP_BACK_EDGE, sepv_pkg::OP_FRONT_EDGE};
  assign is_repeat = edge_dir == last_direction;
  assign delta     = events.timestamp_us - last_event_time;
  assign vel_mag   = {1'b0, quotient};

  always_comb begin
    state_next    = state;
    events.ready  = 1'b0;
    div_start     = 1'b0;
    result_now    = 1'b0;
    case (state)
      sepv_pkg::ST_IDLE: begin
        events.ready = !out_valid || results.ready;
        if (accept) begin
          if (is_edge && is_repeat) begin
            state_next = sepv_pkg::ST_START;
          end else begin
            result_now = 1'b1;
          end
        end
      end
      sepv_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = sepv_pkg::ST_DIV;
      end
      sepv_pkg::ST_DIV: begin
        if (div_done) begin
          result_now = 1'b1;
          state_next = sepv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sepv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sepv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stride_um <= '0;
      max_count <= '0;
    end else if (cfg_we) begin
      case (sepv_pkg::reg_index_t'(cfg_index))
        sepv_pkg::REG_STRIDE:    stride_um <= cfg_data[sepv_pkg::STRIDE_W-1:0];
        sepv_pkg::REG_MAX_COUNT: max_count <= cfg_data[sepv_pkg::MAX_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stripe_pos      <= '0;
      last_direction  <= sepv_pkg::DIR_NONE;
      last_event_time <= '0;
      velocity_reg    <= '0;
    end else if (accept) begin
      case (sepv_pkg::opcode_t'(events.opcode))
        sepv_pkg::OP_FRONT_MARKER: stripe_pos <= '0;
        sepv_pkg::OP_BACK_MARKER: begin
          stripe_pos <= {1'b0, max_count};
        end
        default: begin
          last_event_time <= events.timestamp_us;
          last_direction  <= edge_dir;
          if (!is_repeat) begin
            velocity_reg <= '0;
          end
        end
      endcase
    end else if (state == sepv_pkg::ST_DIV && div_done) begin
      if (last_direction == sepv_pkg::DIR_RIGHT) begin
        stripe_pos   <= stripe_pos + sepv_pkg::COUNT_W'(1);
        velocity_reg <= vel_mag;
      end else begin
        stripe_pos   <= stripe_pos - sepv_pkg::COUNT_W'(1);
        velocity_reg <= '0 - vel_mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dividend <= {{sepv_pkg::SCALE_W{1'b0}}, stride_um} *
                  sepv_pkg::DIVIDEND_W'(sepv_pkg::VEL_SCALE);
      divisor  <= (delta == '0) ? sepv_pkg::DIVISOR_W'(1) : delta;
    end
  end

  sepv_div #(
    .DividendWidth(sepv_pkg::DIVIDEND_W),
    .DivisorWidth (sepv_pkg::DIVISOR_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dividend),
    .divisor (divisor),
    .done    (div_done),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_now) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid          = out_valid;
  assign results.position_count = stripe_pos;
  assign results.velocity_mm_s  = velocity_reg;
  assign results.moving_right   = last_direction == sepv_pkg::DIR_RIGHT;

  a_no_ready_in_work: assert property (@(posedge clk) disable iff (rst)
    state != sepv_pkg::ST_IDLE |-> !events.ready)
    else $error("events ready while an event is in work");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |=> results.valid && $stable(results.position_count))
    else $error("pending result lost or changed under stall");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == sepv_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  a_marker_result: assert property (@(posedge clk) disable iff (rst)
    accept && !is_edge |=> results.valid && state == sepv_pkg::ST_IDLE)
    else $error("marker event gave no result on the next cycle");

endmodule
